// ----- hdl/stream_find_and_replace_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stream find-and-replace block
// Shared property forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_AND_REPLACE_ASSERT_SVH
`define STREAM_FIND_AND_REPLACE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfr assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfr assertion failed");

`endif

// ----- hdl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the stream find-and-replace modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int PAT_LIM     = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
  localparam int LEN_W       = 4;
  localparam int IDX_W       = 3;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 64;

  typedef enum logic [1:0] {
    REG_PAT_BYTES = 2'd0,
    REG_PAT_LEN   = 2'd1,
    REG_REP_BYTES = 2'd2,
    REG_REP_LEN   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0][7:0]   pat_bytes;
    logic [LEN_W-1:0]  pat_len;
    logic [7:0][7:0]   rep_bytes;
    logic [LEN_W-1:0]  rep_len;
    logic              win_clear;
  } cfg_t;

  typedef struct packed {
    logic [7:0][7:0]   data;
    logic [LEN_W-1:0]  cnt;
    logic              bare;
    logic              last;
  } burst_t;

endpackage

`default_nettype wire

// ----- hdl/stream_find_and_replace.sv -----
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Streaming byte find-and-replace with a configurable pattern and replacement.
// ----------------------------------------------------------------------------
// At most one byte is taken per cycle. A byte that yields zero or one output
// word holds the input at most until that word leaves, so plain text streams
// at one byte per cycle while out_ready is high. A byte that yields a burst
// of k words (a replacement, or the flush on the last byte) holds the input
// while the result register hands the burst out; the next byte is taken in
// the cycle its final word leaves. Configuration is to be written by the
// user while the block is idle, which the block does not enforce; writing the pattern length empties the window.
`default_nettype none

module stream_find_and_replace
  import sfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [7:0]        out_byte,
  output logic                   out_byte_valid,
  output logic                   out_run_end,
  output logic                   out_stream_end
);

  cfg_t   cfg;
  burst_t burst;
  logic   emit;
  logic   accept;

  assign accept = in_valid & in_ready;

  sfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfr_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .burst   (burst),
    .emit    (emit)
  );

  sfr_burst u_burst (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (accept & emit),
    .burst          (burst),
    .take_ok        (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_end    (out_run_end),
    .out_stream_end (out_stream_end)
  );

endmodule

`default_nettype wire

// ----- hdl/sfr_cfg.sv -----
// ----------------------------------------------------------------------------
// sfr_cfg
// Configuration registers behind the APB-style port, with clamped lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_cfg
  import sfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [DATA_W-1:0] pat_bytes_r;
  logic [LEN_W-1:0]  pat_len_r;
  logic [DATA_W-1:0] rep_bytes_r;
  logic [LEN_W-1:0]  rep_len_r;
  logic              wr_en;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= LEN_W'(1);
      rep_bytes_r <= '0;
      rep_len_r   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PAT_BYTES: pat_bytes_r <= pwdata;
        REG_PAT_LEN:   pat_len_r   <= pwdata[LEN_W-1:0];
        REG_REP_BYTES: rep_bytes_r <= pwdata;
        REG_REP_LEN:   rep_len_r   <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PAT_BYTES: prdata = pat_bytes_r;
      REG_PAT_LEN:   prdata = {{(DATA_W-LEN_W){1'b0}}, pat_len_r};
      REG_REP_BYTES: prdata = rep_bytes_r;
      REG_REP_LEN:   prdata = {{(DATA_W-LEN_W){1'b0}}, rep_len_r};
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    cfg.pat_bytes = pat_bytes_r;
    cfg.rep_bytes = rep_bytes_r;
    priority if (pat_len_r == '0) begin
      cfg.pat_len = LEN_W'(1);
    end else if (pat_len_r > LEN_W'(PAT_LIM)) begin
      cfg.pat_len = LEN_W'(PAT_LIM);
    end else begin
      cfg.pat_len = pat_len_r;
    end
    cfg.rep_len   = (rep_len_r > LEN_W'(8)) ? LEN_W'(8) : rep_len_r;
    cfg.win_clear = wr_en && (idx == REG_PAT_LEN);
  end

endmodule

`default_nettype wire

// ----- hdl/sfr_window.sv -----
// ----------------------------------------------------------------------------
// sfr_window
// Sliding window and match logic; turns one input byte into a result burst.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_window
  import sfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output burst_t          burst,
  output logic            emit
);

  logic [PAT_LIM-1:0][7:0] win_r;
  logic [PAT_LIM-1:0][7:0] win_nxt;
  logic [LEN_W-1:0]        fill_r;
  logic [LEN_W-1:0]        fill_nxt;
  logic [PAT_LIM-1:0][7:0] w_post;
  logic [PAT_LIM-1:0][7:0] w_shift;
  logic [LEN_W-1:0]        fill_in;
  logic [LEN_W-1:0]        fill1;
  logic                    full;
  logic                    match;

  always_comb begin
    fill_in = (fill_r >= cfg.pat_len) ? '0 : fill_r;
    w_post  = win_r;
    w_post[fill_in[IDX_W-1:0]] = in_byte;
    fill1   = fill_in + LEN_W'(1);
    full    = (fill1 == cfg.pat_len);
    match   = 1'b1;
    for (int i = 0; i < PAT_LIM; i++) begin
      if ((LEN_W'(i) < cfg.pat_len) && (w_post[i] != cfg.pat_bytes[i])) begin
        match = 1'b0;
      end
    end
    for (int i = 0; i < PAT_LIM - 1; i++) begin
      w_shift[i] = w_post[i+1];
    end
    w_shift[PAT_LIM-1] = w_post[PAT_LIM-1];
  end

  always_comb begin
    burst.data = w_post;
    burst.cnt  = '0;
    burst.bare = 1'b0;
    burst.last = in_last;
    win_nxt    = w_post;
    fill_nxt   = fill1;
    priority if (full && match) begin
      burst.data = cfg.rep_bytes;
      burst.cnt  = cfg.rep_len;
      fill_nxt   = '0;
    end else if (full) begin
      burst.cnt  = in_last ? cfg.pat_len : LEN_W'(1);
      win_nxt    = w_shift;
      fill_nxt   = cfg.pat_len - LEN_W'(1);
    end else begin
      burst.cnt  = in_last ? fill1 : '0;
    end
    if (in_last) begin
      fill_nxt = '0;
      if (burst.cnt == '0) begin
        burst.cnt     = LEN_W'(1);
        burst.bare    = 1'b1;
        burst.data[0] = '0;
      end
    end
    emit = (burst.cnt != '0);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cfg.win_clear) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sfr_burst.sv -----
// ----------------------------------------------------------------------------
// sfr_burst
// Result register that hands a burst out one word per output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_burst
  import sfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire burst_t     burst,
  output logic            take_ok,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_run_end,
  output logic            out_stream_end
);

  logic [7:0][7:0]         data_r;
  logic [LEN_W-1:0]        cnt_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    bare_r;
  logic                    last_r;
  logic                    valid_r;
  logic                    run_end;
  logic                    done;

  assign run_end        = ({1'b0, idx_r} == (cnt_r - LEN_W'(1)));
  assign done           = valid_r & out_ready & run_end;
  assign take_ok        = ~valid_r | done;
  assign out_valid      = valid_r;
  assign out_byte       = data_r[idx_r];
  assign out_byte_valid = ~bare_r;
  assign out_run_end    = run_end;
  assign out_stream_end = run_end & last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (done) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (valid_r && out_ready) begin
      idx_r   <= idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= burst.data;
      cnt_r  <= burst.cnt;
      bare_r <= burst.bare;
      last_r <= burst.last;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sfr_checker.sv -----
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks for the stream find-and-replace block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stream_find_and_replace_assert.svh"

module sfr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_byte_valid,
  input wire logic       out_run_end,
  input wire logic       out_stream_end
);

  `SFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_run_end))
  `SFR_ASSERT_NOW(a_end_in_run, out_valid && out_stream_end, out_run_end)
  `SFR_ASSERT_NOW(a_bare_marker, out_valid && !out_byte_valid, out_stream_end && out_byte == 8'd0)
  `SFR_ASSERT_NOW(a_stall_cause, !in_ready, out_valid)

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (.*);

`default_nettype wire
